// ===== rtl/urm_pkg.sv =====
`default_nettype none

package urm_pkg;

    // defaults for the top level parameters
    localparam int DEF_HISTORY_LEN = 5;
    localparam int DEF_COUNT_WIDTH = 16;

    // field widths
    localparam int DIST_W      = 16;
    localparam int GAP_W       = 16;
    localparam int TRIG_W      = 8;
    localparam int TOUT_W      = 16;
    localparam int SCALE_W     = 18;
    localparam int SCALE_SHIFT = 16;
    localparam int DIST_MAX    = 65535;

    // configuration port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // register reset values
    localparam logic [GAP_W-1:0]   GAP_RST   = GAP_W'(10000);
    localparam logic [TRIG_W-1:0]  TRIG_RST  = TRIG_W'(10);
    localparam logic [TOUT_W-1:0]  TOUT_RST  = TOUT_W'(15000);
    localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(112605);

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [2:0] {
        REG_ENABLE  = 3'd0,
        REG_GAP     = 3'd1,
        REG_TRIGGER = 3'd2,
        REG_TIMEOUT = 3'd3,
        REG_SCALE   = 3'd4
    } t_reg_idx;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_GAP  = 3'd1,
        PH_TRIG = 3'd2,
        PH_RISE = 3'd3,
        PH_FALL = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE  = 2'd0,
        BK_STORE = 2'd1,
        BK_SCAN  = 2'd2,
        BK_EMIT  = 2'd3
    } t_back_state;

    // configuration as seen by front and back
    typedef struct packed {
        logic               enable;
        logic [GAP_W-1:0]   gap;
        logic [TRIG_W-1:0]  trig;
        logic [TOUT_W-1:0]  tout;
        logic [SCALE_W-1:0] scale;
    } t_cfg;

    // per-tick command from front to back
    typedef struct packed {
        logic trig;
        logic done;
        logic tout;
        logic clear;
        logic store;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/urm_front.sv =====
`default_nettype none

module urm_front #(
    parameter int COUNT_WIDTH = urm_pkg::DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  urm_pkg::t_cfg          i_cfg,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  logic                   i_echo_level,
    input  logic                   i_q_full,
    output logic                   o_push,
    output urm_pkg::t_cmd          o_cmd,
    output logic [COUNT_WIDTH-1:0] o_width
);
    import urm_pkg::*;

    localparam int CMP_W = ((COUNT_WIDTH > TOUT_W) ? COUNT_WIDTH : TOUT_W) + 1;
    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << COUNT_WIDTH) - 64'd1);

    t_phase                 r_phase, n_phase, w_phase_eff;
    logic [COUNT_WIDTH-1:0] r_tick, n_tick, w_tick_eff;
    logic [COUNT_WIDTH-1:0] r_width, n_width, w_width_eff;
    logic                   r_enable_seen;
    logic                   w_accept, w_starting;
    logic [CMP_W-1:0]       w_tout_ext, w_tick_next;
    logic [COUNT_WIDTH-1:0] w_limit;
    logic                   w_gap_hit, w_trig_hit, w_rise_late, w_fall_late;

    assign o_in_ready = ~i_q_full;
    assign w_accept   = i_in_valid & o_in_ready;
    assign o_push     = w_accept;

    // a rising enable restarts the round from the gap
    assign w_starting  = i_cfg.enable & ~r_enable_seen;
    assign w_phase_eff = w_starting ? PH_GAP : r_phase;
    assign w_tick_eff  = w_starting ? '0 : r_tick;
    assign w_width_eff = w_starting ? '0 : r_width;

    // timeout clamped to what the counter holds
    assign w_tout_ext = CMP_W'(i_cfg.tout);
    assign w_limit    = (w_tout_ext > COUNT_MAX) ? COUNT_WIDTH'(COUNT_MAX)
                                                 : COUNT_WIDTH'(w_tout_ext);

    assign w_tick_next = CMP_W'(w_tick_eff) + CMP_W'(1);
    assign w_gap_hit   = w_tick_next >= CMP_W'(i_cfg.gap);
    assign w_trig_hit  = w_tick_next >= CMP_W'(i_cfg.trig);
    assign w_rise_late = w_tick_eff >= w_limit;
    assign w_fall_late = w_width_eff >= w_limit;

    // next state
    always_comb begin
        n_phase = w_phase_eff;
        n_tick  = w_tick_eff;
        n_width = w_width_eff;
        if (!i_cfg.enable) begin
            n_phase = PH_IDLE;
            n_tick  = '0;
            n_width = '0;
        end else begin
            unique case (w_phase_eff)
                PH_GAP: begin
                    if (w_gap_hit) begin
                        n_phase = PH_TRIG;
                        n_tick  = '0;
                    end else begin
                        n_tick = COUNT_WIDTH'(w_tick_next);
                    end
                end
                PH_TRIG: begin
                    if (w_trig_hit) begin
                        n_phase = PH_RISE;
                        n_tick  = '0;
                    end else begin
                        n_tick = COUNT_WIDTH'(w_tick_next);
                    end
                end
                PH_RISE: begin
                    if (i_echo_level) begin
                        n_phase = PH_FALL;
                        n_width = COUNT_WIDTH'(1);
                    end else if (w_rise_late) begin
                        n_phase = PH_GAP;
                        n_tick  = '0;
                    end else begin
                        n_tick = COUNT_WIDTH'(w_tick_next);
                    end
                end
                PH_FALL: begin
                    if (!i_echo_level || w_fall_late) begin
                        n_phase = PH_GAP;
                        n_tick  = '0;
                    end else begin
                        n_width = w_width_eff + COUNT_WIDTH'(1);
                    end
                end
                default: begin
                    n_phase = PH_GAP;
                    n_tick  = '0;
                end
            endcase
        end
    end

    // command for this tick
    always_comb begin
        o_cmd       = '0;
        o_cmd.clear = w_starting;
        o_width     = w_width_eff;
        if (i_cfg.enable) begin
            unique case (w_phase_eff)
                PH_TRIG: o_cmd.trig = 1'b1;
                PH_RISE: o_cmd.tout = ~i_echo_level & w_rise_late;
                PH_FALL: begin
                    o_cmd.done  = ~i_echo_level;
                    o_cmd.store = ~i_echo_level;
                    o_cmd.tout  = i_echo_level & w_fall_late;
                end
                default: o_cmd.trig = 1'b0;
            endcase
        end
    end

    // round state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_tick        <= '0;
            r_width       <= '0;
            r_enable_seen <= 1'b0;
        end else if (w_accept) begin
            r_phase       <= n_phase;
            r_tick        <= n_tick;
            r_width       <= n_width;
            r_enable_seen <= i_cfg.enable;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/urm_queue.sv =====
`default_nettype none

module urm_queue #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_pop
);
    import urm_pkg::*;

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + QCNT_W'(1);
                2'b01:   r_count <= r_count - QCNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/urm_back.sv =====
`default_nettype none

module urm_back #(
    parameter int HISTORY_LEN = urm_pkg::DEF_HISTORY_LEN,
    parameter int COUNT_WIDTH = urm_pkg::DEF_COUNT_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  urm_pkg::t_cfg              i_cfg,
    input  logic                       i_q_valid,
    input  urm_pkg::t_cmd              i_cmd,
    input  logic [COUNT_WIDTH-1:0]     i_width,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_trigger_level,
    output logic                       o_sample_done,
    output logic                       o_sample_timed_out,
    output logic [urm_pkg::DIST_W-1:0] o_last_distance_centi,
    output logic [urm_pkg::DIST_W-1:0] o_median_distance_centi
);
    import urm_pkg::*;

    localparam int IDX_W  = (HISTORY_LEN > 1) ? $clog2(HISTORY_LEN) : 1;
    localparam int FILL_W = $clog2(HISTORY_LEN + 1);
    localparam int PROD_W = COUNT_WIDTH + SCALE_W;

    t_back_state        r_state, n_state;
    logic [PROD_W-1:0]  r_prod;
    logic [PROD_W-1:0]  w_shifted;
    logic [DIST_W-1:0]  w_dist;
    logic [DIST_W-1:0]  r_hist [HISTORY_LEN];
    logic [FILL_W-1:0]  r_fill;
    logic [IDX_W-1:0]   r_slot;
    logic [IDX_W-1:0]   r_cand;
    logic [DIST_W-1:0]  r_last, r_median;
    logic [DIST_W-1:0]  w_cand_val;
    logic [FILL_W-1:0]  w_rank;
    logic               w_hit;
    logic               w_out_free;
    logic               w_emit, w_mul, w_store, w_clear;
    logic               r_out_valid, r_out_trig, r_out_done, r_out_tout;
    logic [DIST_W-1:0]  r_out_last, r_out_median;

    assign w_out_free = ~r_out_valid | i_out_ready;

    // scaled distance, saturated
    assign w_shifted = r_prod >> SCALE_SHIFT;
    assign w_dist    = (w_shifted > PROD_W'(DIST_MAX)) ? DIST_W'(DIST_MAX)
                                                       : w_shifted[DIST_W-1:0];

    // stable rank of the candidate among the filled entries
    assign w_cand_val = r_hist[r_cand];
    always_comb begin
        w_rank = '0;
        for (int j = 0; j < HISTORY_LEN; j++) begin
            if ((FILL_W'(j) < r_fill) &&
                ((r_hist[j] < w_cand_val) ||
                 ((r_hist[j] == w_cand_val) && (IDX_W'(j) < r_cand)))) begin
                w_rank = w_rank + FILL_W'(1);
            end
        end
    end
    assign w_hit = (w_rank == (r_fill >> 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid && i_cmd.store) begin
                    n_state = BK_STORE;
                end
            end
            BK_STORE: n_state = BK_SCAN;
            BK_SCAN: begin
                if (w_hit) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (w_out_free) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // controls
    always_comb begin
        w_emit  = 1'b0;
        w_mul   = 1'b0;
        w_store = 1'b0;
        w_clear = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                w_mul   = i_q_valid & i_cmd.store;
                w_emit  = i_q_valid & ~i_cmd.store & w_out_free;
                w_clear = w_emit & i_cmd.clear;
            end
            BK_STORE: w_store = 1'b1;
            BK_EMIT:  w_emit  = w_out_free;
            default:  w_emit  = 1'b0;
        endcase
    end
    assign o_pop = w_emit;

    // product and history entries
    always_ff @(posedge i_clk) begin
        if (w_mul) begin
            r_prod <= PROD_W'(i_width) * PROD_W'(i_cfg.scale);
        end
        if (w_store) begin
            r_hist[r_slot] <= w_dist;
        end
    end

    // ring control, results and scan index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BK_IDLE;
            r_fill   <= '0;
            r_slot   <= '0;
            r_cand   <= '0;
            r_last   <= '0;
            r_median <= '0;
        end else begin
            r_state <= n_state;
            if (w_clear) begin
                r_fill   <= '0;
                r_slot   <= '0;
                r_last   <= '0;
                r_median <= '0;
            end
            if (w_store) begin
                r_last <= w_dist;
                r_cand <= '0;
                r_slot <= (r_slot == IDX_W'(HISTORY_LEN - 1)) ? '0 : r_slot + IDX_W'(1);
                if (r_fill < FILL_W'(HISTORY_LEN)) begin
                    r_fill <= r_fill + FILL_W'(1);
                end
            end
            if (r_state == BK_SCAN) begin
                if (w_hit) begin
                    r_median <= w_cand_val;
                end else begin
                    r_cand <= r_cand + IDX_W'(1);
                end
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_trig   <= i_cmd.trig;
            r_out_done   <= i_cmd.done;
            r_out_tout   <= i_cmd.tout;
            r_out_last   <= i_cmd.clear ? '0 : r_last;
            r_out_median <= i_cmd.clear ? '0 : r_median;
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_trigger_level         = r_out_trig;
    assign o_sample_done           = r_out_done;
    assign o_sample_timed_out      = r_out_tout;
    assign o_last_distance_centi   = r_out_last;
    assign o_median_distance_centi = r_out_median;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(HISTORY_LEN))
        else $error("history fill above length");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_slot} < (IDX_W + 1)'(HISTORY_LEN))
        else $error("write slot out of range");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_SCAN) |-> (FILL_W'(r_cand) < r_fill))
        else $error("median scan ran past filled entries");

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> i_q_valid)
        else $error("pop from empty queue");

    a_clear_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clear |=> (r_fill == '0))
        else $error("history not cleared");

endmodule

`default_nettype wire

// ===== rtl/ultrasonic_ranging_median_top.sv =====
`default_nettype none

// Ultrasonic echo ranging with a median filter. Each input beat is one
// microsecond tick carrying the sampled echo level, and each tick yields
// exactly one output beat: the trigger pin level for that tick, pulses for a
// good measurement or a timeout, the latest distance and the median of the
// last HISTORY_LEN good distances, both in hundredths of a centimetre. The
// front steps the round (gap, trigger, wait for rise, wait for fall) once
// per accepted tick and hands a command to a two-entry queue; the back
// carries it out. A plain tick goes straight from the queue head into the
// output register. A tick that completes a measurement steps the back
// through a multiply, the history write, one rank compare per history
// entry until the median is found, then the state that registers its
// beat. The queue and the output register let the front take the
// next tick meanwhile. Registers at byte addresses 0x00 enable, 0x04
// gap_ticks, 0x08 trigger_ticks, 0x0C timeout_ticks, 0x10 scale_factor;
// write them only while no tick is in flight. No clearing pass follows reset.

module ultrasonic_ranging_median_top #(
    parameter int HISTORY_LEN = urm_pkg::DEF_HISTORY_LEN,
    parameter int COUNT_WIDTH = urm_pkg::DEF_COUNT_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [urm_pkg::ADDR_W-1:0] paddr,
    input  logic [urm_pkg::DATA_W-1:0] pwdata,
    output logic [urm_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    // tick input
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_echo_level,
    // result output
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_trigger_level,
    output logic                       o_sample_done,
    output logic                       o_sample_timed_out,
    output logic [urm_pkg::DIST_W-1:0] o_last_distance_centi,
    output logic [urm_pkg::DIST_W-1:0] o_median_distance_centi
);
    import urm_pkg::*;

    localparam int QW = $bits(t_cmd) + COUNT_WIDTH;

    t_cfg                   r_cfg;
    t_reg_idx               w_idx;
    logic                   w_wr;
    logic                   w_push, w_pop, w_q_full, w_q_valid;
    t_cmd                   w_front_cmd, w_back_cmd;
    logic [COUNT_WIDTH-1:0] w_front_width, w_back_width;
    logic [QW-1:0]          w_q_out;

    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite & pready;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable <= 1'b0;
            r_cfg.gap    <= GAP_RST;
            r_cfg.trig   <= TRIG_RST;
            r_cfg.tout   <= TOUT_RST;
            r_cfg.scale  <= SCALE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_ENABLE:  r_cfg.enable <= pwdata[0];
                REG_GAP:     r_cfg.gap    <= pwdata[GAP_W-1:0];
                REG_TRIGGER: r_cfg.trig   <= pwdata[TRIG_W-1:0];
                REG_TIMEOUT: r_cfg.tout   <= pwdata[TOUT_W-1:0];
                REG_SCALE:   r_cfg.scale  <= pwdata[SCALE_W-1:0];
                default:     r_cfg.enable <= r_cfg.enable;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (w_idx)
            REG_ENABLE:  prdata = DATA_W'(r_cfg.enable);
            REG_GAP:     prdata = DATA_W'(r_cfg.gap);
            REG_TRIGGER: prdata = DATA_W'(r_cfg.trig);
            REG_TIMEOUT: prdata = DATA_W'(r_cfg.tout);
            REG_SCALE:   prdata = DATA_W'(r_cfg.scale);
            default:     prdata = '0;
        endcase
    end

    urm_front #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_echo_level (i_echo_level),
        .i_q_full     (w_q_full),
        .o_push       (w_push),
        .o_cmd        (w_front_cmd),
        .o_width      (w_front_width)
    );

    urm_queue #(
        .WIDTH (QW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_front_cmd, w_front_width}),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .o_data  (w_q_out),
        .i_pop   (w_pop)
    );

    assign w_back_cmd   = t_cmd'(w_q_out[QW-1:COUNT_WIDTH]);
    assign w_back_width = w_q_out[COUNT_WIDTH-1:0];

    urm_back #(
        .HISTORY_LEN (HISTORY_LEN),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg                   (r_cfg),
        .i_q_valid               (w_q_valid),
        .i_cmd                   (w_back_cmd),
        .i_width                 (w_back_width),
        .o_pop                   (w_pop),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_trigger_level         (o_trigger_level),
        .o_sample_done           (o_sample_done),
        .o_sample_timed_out      (o_sample_timed_out),
        .o_last_distance_centi   (o_last_distance_centi),
        .o_median_distance_centi (o_median_distance_centi)
    );

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import urm_pkg::*;

    localparam int HIST_LEN      = DEF_HISTORY_LEN;
    localparam int CNT_MAX       = (1 << DEF_COUNT_WIDTH) - 1;
    localparam int HOLD_CYCLES   = 80;
    localparam int STALL_LIMIT   = 2000;
    localparam int RANDOM_TICKS  = 900;
    localparam int CALM_TICKS    = 150;
    localparam int SETTLE_CYCLES = 20;
    localparam int MAX_PRINTS    = 40;

    // one result beat as predicted or as seen on the output
    typedef struct packed {
        logic              trig;
        logic              done;
        logic              tout;
        logic [DIST_W-1:0] last_d;
        logic [DIST_W-1:0] median_d;
    } range_beat_t;

    // ranging predictor plus the queue of beats still owed by the block
    class ranging_scoreboard;
        bit               enable;
        bit [GAP_W-1:0]   gap;
        bit [TRIG_W-1:0]  trig_len;
        bit [TOUT_W-1:0]  tout;
        bit [SCALE_W-1:0] scale;
        t_phase           phase;
        int unsigned      tick_count;
        int unsigned      pulse_len;
        bit [DIST_W-1:0]  history [HIST_LEN];
        int unsigned      fill;
        int unsigned      slot;
        bit [DIST_W-1:0]  last_d;
        bit [DIST_W-1:0]  median_d;
        bit               enable_seen;
        range_beat_t      expected_beats [$];
        int unsigned      errors;

        function new();
            enable      = 1'b0;
            gap         = GAP_RST;
            trig_len    = TRIG_RST;
            tout        = TOUT_RST;
            scale       = SCALE_RST;
            phase       = PH_IDLE;
            tick_count  = 0;
            pulse_len   = 0;
            enable_seen = 1'b0;
            errors      = 0;
            clear_history();
        endfunction

        function void clear_history();
            foreach (history[i]) history[i] = '0;
            fill     = 0;
            slot     = 0;
            last_d   = '0;
            median_d = '0;
        endfunction

        function void set_reg(t_reg_idx idx, bit [DATA_W-1:0] value);
            case (idx)
                REG_ENABLE:  enable   = value[0];
                REG_GAP:     gap      = value[GAP_W-1:0];
                REG_TRIGGER: trig_len = value[TRIG_W-1:0];
                REG_TIMEOUT: tout     = value[TOUT_W-1:0];
                REG_SCALE:   scale    = value[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        // scale the echo width, push it into the ring and redo the median
        function void store_distance(int unsigned width);
            bit [63:0]       scaled_d;
            bit [DIST_W-1:0] sorted [HIST_LEN];
            bit [DIST_W-1:0] v;
            int              j;
            scaled_d = (64'(width) * 64'(scale)) >> SCALE_SHIFT;
            last_d = (scaled_d > DIST_MAX) ? DIST_W'(DIST_MAX) : scaled_d[DIST_W-1:0];
            if (slot >= HIST_LEN) slot = 0;
            history[slot] = last_d;
            slot = (slot + 1) % HIST_LEN;
            if (fill < HIST_LEN) fill++;
            for (int i = 0; i < fill; i++) begin
                v = history[i];
                j = i;
                while (j > 0 && sorted[j-1] > v) begin
                    sorted[j] = sorted[j-1];
                    j--;
                end
                sorted[j] = v;
            end
            median_d = sorted[fill / 2];
        endfunction

        // advance the round by one accepted tick and queue its result
        function void take_tick(bit echo);
            range_beat_t beat;
            int unsigned lim;
            beat = '0;
            lim = (tout > CNT_MAX) ? CNT_MAX : tout;
            if (enable && !enable_seen) begin
                clear_history();
                phase      = PH_GAP;
                tick_count = 0;
                pulse_len  = 0;
            end
            enable_seen = enable;
            if (!enable) begin
                phase      = PH_IDLE;
                tick_count = 0;
                pulse_len  = 0;
            end else begin
                case (phase)
                    PH_GAP: begin
                        if (tick_count + 1 >= gap) begin
                            phase      = PH_TRIG;
                            tick_count = 0;
                        end else begin
                            tick_count = (tick_count + 1) & CNT_MAX;
                        end
                    end
                    PH_TRIG: begin
                        beat.trig = 1'b1;
                        if (tick_count + 1 >= trig_len) begin
                            phase      = PH_RISE;
                            tick_count = 0;
                        end else begin
                            tick_count = (tick_count + 1) & CNT_MAX;
                        end
                    end
                    PH_RISE: begin
                        if (echo) begin
                            phase     = PH_FALL;
                            pulse_len = 1;
                        end else if (tick_count >= lim) begin
                            beat.tout  = 1'b1;
                            phase      = PH_GAP;
                            tick_count = 0;
                        end else begin
                            tick_count++;
                        end
                    end
                    PH_FALL: begin
                        if (!echo) begin
                            beat.done = 1'b1;
                            store_distance(pulse_len);
                            phase      = PH_GAP;
                            tick_count = 0;
                        end else if (pulse_len >= lim) begin
                            beat.tout  = 1'b1;
                            phase      = PH_GAP;
                            tick_count = 0;
                        end else begin
                            pulse_len++;
                        end
                    end
                    default: begin
                        phase      = PH_GAP;
                        tick_count = 0;
                    end
                endcase
            end
            beat.last_d   = last_d;
            beat.median_d = median_d;
            expected_beats = {expected_beats, beat};
        endfunction

        task report(string what, longint unsigned want, longint unsigned got);
            errors++;
            if (errors <= MAX_PRINTS)
                $display("mismatch %s: expected %0d got %0d at %0t", what, want, got, $time);
        endtask

        task check_beat(range_beat_t got);
            range_beat_t want;
            if (expected_beats.size() == 0) begin
                report("beat with nothing expected", 0, 0);
                return;
            end
            want = expected_beats.pop_front();
            if (got.trig !== want.trig) report("trigger_level", want.trig, got.trig);
            if (got.done !== want.done) report("sample_done", want.done, got.done);
            if (got.tout !== want.tout) report("sample_timed_out", want.tout, got.tout);
            if (got.last_d !== want.last_d)
                report("last_distance_centi", want.last_d, got.last_d);
            if (got.median_d !== want.median_d)
                report("median_distance_centi", want.median_d, got.median_d);
        endtask
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              i_in_valid;
    logic              o_in_ready;
    logic              i_echo_level;
    logic              o_out_valid;
    logic              i_out_ready;
    logic              o_trigger_level;
    logic              o_sample_done;
    logic              o_sample_timed_out;
    logic [DIST_W-1:0] o_last_distance_centi;
    logic [DIST_W-1:0] o_median_distance_centi;

    ranging_scoreboard sb = new();
    bit                calm = 1'b0;
    bit                hold_req = 1'b0;
    int unsigned       ticks_sent = 0;

    ultrasonic_ranging_median_top dut (.*);

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // check every beat the block hands out
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_beat({o_trigger_level, o_sample_done, o_sample_timed_out,
                           o_last_distance_centi, o_median_distance_centi});
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        i_out_ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // watchdog on cycles without any beat moving
    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic write_reg(input t_reg_idx idx, input bit [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_reg(idx, value);
        @(posedge i_clk);
    endtask

    // offer one tick, with an occasional idle burst ahead of it
    task automatic send_tick(input bit echo);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_echo_level <= echo;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_tick(echo);
        ticks_sent++;
    endtask

    // stop offering and let every owed beat come out
    task automatic wait_quiet();
        i_in_valid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // one well-formed round: lows until the echo wait, then delay lows,
    // then an echo of the given width and a falling edge
    task automatic run_round(input int unsigned delay_len, input int unsigned width_len);
        while (sb.phase != PH_RISE) send_tick(1'b0);
        repeat (delay_len) if (sb.phase == PH_RISE) send_tick(1'b0);
        if (sb.phase == PH_RISE) begin
            send_tick(1'b1);
            while (sb.phase == PH_FALL && sb.pulse_len < width_len) send_tick(1'b1);
            if (sb.phase == PH_FALL) send_tick(1'b0);
        end
    endtask

    initial begin
        int unsigned random_start;
        int unsigned phase_no;
        int unsigned span;
        int unsigned delay_len;
        int unsigned width_len;
        i_rst_n      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        i_in_valid   <= 1'b0;
        i_echo_level <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // disabled: no trigger, no pulses, results at zero
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        wait_quiet();

        // shortest gap and trigger, tiny timeout, distance equals width, then zero scale
        write_reg(REG_GAP, 0);
        write_reg(REG_TRIGGER, 1);
        write_reg(REG_TIMEOUT, 3);
        write_reg(REG_SCALE, 32'h10000);
        write_reg(REG_ENABLE, 1);
        run_round(0, 1);
        run_round(2, 3);
        run_round(4, 1);
        run_round(0, 5);
        run_round(1, 2);
        wait_quiet();
        write_reg(REG_SCALE, 0);
        run_round(0, 2);
        wait_quiet();

        // disabled holds results, re-enable clears them
        write_reg(REG_ENABLE, 0);
        send_tick(1'b1);
        send_tick(1'b0);
        wait_quiet();

        // longest trigger and timeout, largest scale, then longest gap
        write_reg(REG_TRIGGER, 255);
        write_reg(REG_TIMEOUT, 65535);
        write_reg(REG_SCALE, 262143);
        write_reg(REG_ENABLE, 1);
        run_round(0, 200);
        wait_quiet();
        write_reg(REG_GAP, 65535);
        repeat (8) send_tick(1'b0);
        wait_quiet();

        // random rounds under random settings
        random_start = ticks_sent;
        phase_no = 0;
        while (ticks_sent - random_start < RANDOM_TICKS) begin
            wait_quiet();
            phase_no++;
            if (phase_no == 1 || $urandom_range(0, 1) == 0)
                write_reg(REG_GAP, ($urandom_range(0, 4) == 0) ?
                          $urandom_range(0, 60) : $urandom_range(0, 6));
            if (phase_no == 1 || $urandom_range(0, 1) == 0)
                write_reg(REG_TRIGGER, ($urandom_range(0, 6) == 0) ?
                          $urandom_range(1, 40) : $urandom_range(1, 6));
            if (phase_no == 1 || $urandom_range(0, 1) == 0)
                write_reg(REG_TIMEOUT, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(1, 65535) : $urandom_range(1, 12));
            if (phase_no == 1 || $urandom_range(0, 1) == 0)
                write_reg(REG_SCALE, $urandom_range(0, 262143));
            write_reg(REG_ENABLE, ($urandom_range(0, 6) != 0));
            if (ticks_sent - random_start >= RANDOM_TICKS - CALM_TICKS) calm = 1'b1;
            if ((phase_no == 3 || phase_no == 9) && !calm) hold_req = 1'b1;

            if (sb.enable) begin
                repeat ($urandom_range(3, 10)) begin
                    if ($urandom_range(0, 6) == 0) begin
                        // noise and broken rounds
                        repeat ($urandom_range(1, 6)) send_tick($urandom_range(0, 1));
                    end else begin
                        span = (sb.tout > 20) ? 20 : sb.tout;
                        delay_len = ($urandom_range(0, 9) == 0 && sb.tout <= 20) ?
                                    sb.tout + $urandom_range(1, 2) : $urandom_range(0, span);
                        width_len = ($urandom_range(0, 9) == 0 && sb.tout <= 20) ?
                                    sb.tout + $urandom_range(1, 2) : $urandom_range(1, span);
                        run_round(delay_len, width_len);
                    end
                end
            end else begin
                repeat ($urandom_range(5, 20)) send_tick($urandom_range(0, 1));
            end
        end

        wait_quiet();
        if (sb.errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
